@@ hdl/drs_pkg.sv @@
// Shared types and constants for the disk request scheduler.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package drs_pkg;

   localparam int unsigned TRACK_W   = 12;
   localparam int unsigned DATA_W    = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned SEEK_W    = 12;
   localparam int unsigned PEND_W    = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_W     = 12;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_SERVED   = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      POL_FCFS  = 2'd0,
      POL_SSTF  = 2'd1,
      POL_SWEEP = 2'd2,
      POL_BATCH = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      CSR_POLICY      = 2'd0,
      CSR_CIRCULAR    = 2'd1,
      CSR_START_TRACK = 2'd2,
      CSR_START_UP    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_PLACE,
      PTR_INC
   } ptr_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUB_START,
      S_SUB_WALK,
      S_SRV_START,
      S_MERGE_LOAD,
      S_MERGE_START,
      S_MERGE_WALK,
      S_SRV_TURN,
      S_SRV_SEARCH,
      S_SRV_TAKE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       latch_in;
      ptr_op_type ptr_op;
      logic       set_mode;
      logic       ins_sub;
      logic       ins_wait;
      logic       merge_load;
      logic       ins_merge;
      logic       turn;
      logic       best_init;
      logic       sstf_step;
      logic       take;
      logic       status_load;
      status_type status_val;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      policy_type policy;
      logic       full;
      logic       act_zero;
      logic       count_zero;
      logic       merge_done;
      logic       walk_cont;
      logic       ptr_at_act;
      logic       out_free;
   } stat_type;

endpackage
`default_nettype wire

@@ hdl/drs_ctrl.sv @@
// Sequencing state machine of the disk request scheduler.
// Uses drs_pkg for the state, command and status types.
`default_nettype none
module drs_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_service,
   input  drs_pkg::stat_type      stat,
   output logic                   req_ready,
   output drs_pkg::cmd_type       cmd
);

   drs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drs_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = req_service ? drs_pkg::S_SRV_START : drs_pkg::S_SUB_START;
            end
         end
         drs_pkg::S_SUB_START: begin
            if (stat.full || stat.policy == drs_pkg::POL_BATCH) begin
               state_in = drs_pkg::S_FINISH;
            end else begin
               state_in = drs_pkg::S_SUB_WALK;
            end
         end
         drs_pkg::S_SUB_WALK: begin
            if (!stat.walk_cont) begin
               state_in = drs_pkg::S_FINISH;
            end
         end
         drs_pkg::S_SRV_START: begin
            if (stat.act_zero && !stat.count_zero) begin
               state_in = drs_pkg::S_MERGE_LOAD;
            end else begin
               state_in = drs_pkg::S_SRV_TURN;
            end
         end
         drs_pkg::S_MERGE_LOAD: begin
            state_in = stat.merge_done ? drs_pkg::S_SRV_TURN : drs_pkg::S_MERGE_START;
         end
         drs_pkg::S_MERGE_START: state_in = drs_pkg::S_MERGE_WALK;
         drs_pkg::S_MERGE_WALK: begin
            if (!stat.walk_cont) begin
               state_in = drs_pkg::S_MERGE_LOAD;
            end
         end
         drs_pkg::S_SRV_TURN: begin
            if (stat.act_zero) begin
               state_in = drs_pkg::S_FINISH;
            end else if (stat.policy == drs_pkg::POL_SSTF) begin
               state_in = drs_pkg::S_SRV_SEARCH;
            end else begin
               state_in = drs_pkg::S_SRV_TAKE;
            end
         end
         drs_pkg::S_SRV_SEARCH: begin
            if (stat.ptr_at_act) begin
               state_in = drs_pkg::S_SRV_TAKE;
            end
         end
         drs_pkg::S_SRV_TAKE: state_in = drs_pkg::S_FINISH;
         drs_pkg::S_FINISH: begin
            if (stat.out_free) begin
               state_in = drs_pkg::S_IDLE;
            end
         end
         default: state_in = drs_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         drs_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.latch_in = req_valid;
         end
         drs_pkg::S_SUB_START: begin
            if (stat.full) begin
               cmd.status_load = 1'b1;
               cmd.status_val  = drs_pkg::ST_FULL;
            end else if (stat.policy == drs_pkg::POL_BATCH) begin
               cmd.ins_wait    = 1'b1;
               cmd.status_load = 1'b1;
               cmd.status_val  = drs_pkg::ST_ACCEPTED;
            end else begin
               cmd.set_mode = 1'b1;
               cmd.ptr_op   = drs_pkg::PTR_PLACE;
            end
         end
         drs_pkg::S_SUB_WALK: begin
            if (stat.walk_cont) begin
               cmd.ptr_op = drs_pkg::PTR_INC;
            end else begin
               cmd.ins_sub     = 1'b1;
               cmd.status_load = 1'b1;
               cmd.status_val  = drs_pkg::ST_ACCEPTED;
            end
         end
         drs_pkg::S_SRV_START: ;
         drs_pkg::S_MERGE_LOAD: cmd.merge_load = !stat.merge_done;
         drs_pkg::S_MERGE_START: begin
            cmd.set_mode = 1'b1;
            cmd.ptr_op   = drs_pkg::PTR_PLACE;
         end
         drs_pkg::S_MERGE_WALK: begin
            if (stat.walk_cont) begin
               cmd.ptr_op = drs_pkg::PTR_INC;
            end else begin
               cmd.ins_merge = 1'b1;
            end
         end
         drs_pkg::S_SRV_TURN: begin
            cmd.turn      = 1'b1;
            cmd.best_init = 1'b1;
            cmd.ptr_op    = drs_pkg::PTR_ZERO;
            if (stat.act_zero) begin
               cmd.status_load = 1'b1;
               cmd.status_val  = drs_pkg::ST_NONE;
            end
         end
         drs_pkg::S_SRV_SEARCH: begin
            if (!stat.ptr_at_act) begin
               cmd.sstf_step = 1'b1;
               cmd.ptr_op    = drs_pkg::PTR_INC;
            end
         end
         drs_pkg::S_SRV_TAKE: begin
            cmd.take        = 1'b1;
            cmd.status_load = 1'b1;
            cmd.status_val  = drs_pkg::ST_SERVED;
         end
         drs_pkg::S_FINISH: cmd.out_load = stat.out_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/drs_datapath.sv @@
// Queue storage, pointers, comparators and result register of the scheduler.
// Uses drs_pkg; driven by drs_ctrl through cmd_type, reports through stat_type.
`default_nettype none
module drs_datapath #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned TRACK_COUNT = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [drs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [drs_pkg::CSR_W-1:0]      csr_wdata,
   input  wire logic [drs_pkg::TRACK_W-1:0]    in_track,
   input  wire logic [drs_pkg::DATA_W-1:0]     in_data,
   input  wire logic [drs_pkg::TIME_W-1:0]     in_time,
   input  drs_pkg::cmd_type                    cmd,
   output drs_pkg::stat_type                   stat,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output drs_pkg::status_type                 rsp_status,
   output logic [drs_pkg::TRACK_W-1:0]         rsp_track,
   output logic [drs_pkg::DATA_W-1:0]          rsp_data,
   output logic [drs_pkg::TIME_W-1:0]          rsp_time,
   output logic [drs_pkg::SEEK_W-1:0]          rsp_seek,
   output logic                                rsp_up,
   output logic [drs_pkg::PEND_W-1:0]          rsp_pending
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned TW = drs_pkg::TRACK_W;
   localparam logic [16:0] TRACK_LIMIT = 17'(TRACK_COUNT);
   localparam logic [TW-1:0] TRACK_TOP = TW'(TRACK_COUNT - 1);

   function automatic logic [TW-1:0] clip(input logic [TW-1:0] t);
      logic [16:0] wide;
      wide = {{(17 - TW){1'b0}}, t};
      return (wide >= TRACK_LIMIT) ? TRACK_TOP : t;
   endfunction

   // configuration
   drs_pkg::policy_type policy_ff;
   logic                circ_ff;

   // queue state
   logic [PW-1:0] ord_slot_ff  [QUEUE_DEPTH];
   logic [PW-1:0] ord_slot_in  [QUEUE_DEPTH];
   logic [TW-1:0] ord_track_ff [QUEUE_DEPTH];
   logic [TW-1:0] ord_track_in [QUEUE_DEPTH];
   logic [CW-1:0] count_ff, count_in, act_ff, act_in, fwd_ff, fwd_in;
   logic [CW-1:0] ptr_ff, ptr_in, pos_ff, pos_in;
   logic [TW:0]   best_ff, best_in;
   logic [TW-1:0] head_ff, head_in;
   logic          dir_ff, dir_in, mode_ff, mode_in;

   // item in flight
   logic [TW-1:0]                 cur_track_ff, cur_track_in;
   logic [drs_pkg::DATA_W-1:0]    cur_data_ff;
   logic [drs_pkg::TIME_W-1:0]    cur_time_ff;
   logic [TW-1:0]                 srv_track_ff, srv_track_in;
   logic [drs_pkg::SEEK_W-1:0]    seek_ff, seek_in;
   drs_pkg::status_type           status_ff, status_in;

   // payload memory, indexed by slot
   logic [drs_pkg::DATA_W-1:0] mem_data [QUEUE_DEPTH];
   logic [drs_pkg::TIME_W-1:0] mem_time [QUEUE_DEPTH];
   logic [drs_pkg::DATA_W-1:0] rd_data_ff;
   logic [drs_pkg::TIME_W-1:0] rd_time_ff;

   // result register
   logic                       rsp_valid_ff;
   drs_pkg::status_type        rsp_status_ff;
   logic [TW-1:0]              rsp_track_ff;
   logic [drs_pkg::DATA_W-1:0] rsp_data_ff;
   logic [drs_pkg::TIME_W-1:0] rsp_time_ff;
   logic [drs_pkg::SEEK_W-1:0] rsp_seek_ff;
   logic                       rsp_up_ff;
   logic [drs_pkg::PEND_W-1:0] rsp_pending_ff;

   // combinational helpers
   logic [PW-1:0] ptr_idx, act_idx, count_idx, pos_idx;
   logic [TW-1:0] walk_q, take_q, sstf_dd, take_dd;
   logic          sweep, gt_q, lt_q, fwd_t_q, fwd_q_t, ahead_head, walk_cont;
   logic          inserting;
   logic [CW-1:0] lo, hi;

   assign ptr_idx   = ptr_ff[PW-1:0];
   assign act_idx   = act_ff[PW-1:0];
   assign count_idx = count_ff[PW-1:0];
   assign pos_idx   = pos_ff[PW-1:0];
   assign sweep     = (policy_ff == drs_pkg::POL_SWEEP) || (policy_ff == drs_pkg::POL_BATCH);

   assign walk_q     = ord_track_ff[ptr_idx];
   assign gt_q       = cur_track_ff > walk_q;
   assign lt_q       = cur_track_ff < walk_q;
   assign fwd_t_q    = dir_ff ? gt_q : lt_q;
   assign fwd_q_t    = dir_ff ? lt_q : gt_q;
   assign ahead_head = sweep && (dir_ff ? (cur_track_ff > head_ff) : (cur_track_ff < head_ff));
   assign walk_cont  = mode_ff ? ((ptr_ff < fwd_ff) && fwd_t_q)
                               : ((ptr_ff < act_ff) && (circ_ff ? fwd_t_q : fwd_q_t));
   assign sstf_dd    = (walk_q > head_ff) ? (walk_q - head_ff) : (head_ff - walk_q);
   assign take_q     = ord_track_ff[pos_idx];
   assign take_dd    = (take_q > head_ff) ? (take_q - head_ff) : (head_ff - take_q);

   assign inserting = cmd.ins_sub || cmd.ins_wait || cmd.ins_merge;
   assign lo = cmd.take ? pos_ff : (cmd.ins_wait ? count_ff : ptr_ff);
   assign hi = cmd.take ? (count_ff - CW'(1)) : (cmd.ins_merge ? act_ff : count_ff);

   always_comb begin
      stat.policy     = policy_ff;
      stat.full       = (count_ff == CW'(QUEUE_DEPTH));
      stat.act_zero   = (act_ff == '0);
      stat.count_zero = (count_ff == '0);
      stat.merge_done = (act_ff == count_ff);
      stat.walk_cont  = walk_cont;
      stat.ptr_at_act = (ptr_ff == act_ff);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in     = count_ff;
      act_in       = act_ff;
      fwd_in       = fwd_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      head_in      = head_ff;
      dir_in       = dir_ff;
      mode_in      = mode_ff;
      cur_track_in = cur_track_ff;
      srv_track_in = srv_track_ff;
      seek_in      = seek_ff;
      status_in    = status_ff;

      if (cmd.latch_in) begin
         cur_track_in = clip(in_track);
         srv_track_in = '0;
         seek_in      = '0;
         if (fwd_ff > act_ff) begin
            fwd_in = act_ff;
         end
      end
      if (cmd.merge_load) begin
         cur_track_in = ord_track_ff[act_idx];
      end
      if (cmd.set_mode) begin
         mode_in = ahead_head;
      end

      case (cmd.ptr_op)
         drs_pkg::PTR_ZERO:  ptr_in = '0;
         drs_pkg::PTR_PLACE: ptr_in = !sweep ? act_ff : (ahead_head ? '0 : fwd_ff);
         drs_pkg::PTR_INC:   ptr_in = ptr_ff + CW'(1);
         default:            ptr_in = ptr_ff;
      endcase

      if (cmd.ins_sub || cmd.ins_wait) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.ins_sub || cmd.ins_merge) begin
         act_in = act_ff + CW'(1);
         if (mode_ff) begin
            fwd_in = fwd_ff + CW'(1);
         end
      end

      if (cmd.turn && sweep && fwd_ff == '0) begin
         dir_in = dir_ff ^ !circ_ff;
         fwd_in = act_ff;
      end
      if (cmd.best_init) begin
         best_in = '1;
         pos_in  = '0;
      end
      if (cmd.sstf_step && ({1'b0, sstf_dd} < best_ff)) begin
         best_in = {1'b0, sstf_dd};
         pos_in  = ptr_ff;
      end

      if (cmd.take) begin
         count_in     = count_ff - CW'(1);
         act_in       = act_ff - CW'(1);
         if (pos_ff < fwd_ff) begin
            fwd_in = fwd_ff - CW'(1);
         end
         head_in      = take_q;
         srv_track_in = take_q;
         seek_in      = take_dd;
      end

      if (cmd.status_load) begin
         status_in = cmd.status_val;
      end

      // register writes only while idle is a user rule; load head and direction
      if (csr_we) begin
         case (drs_pkg::csr_index_type'(csr_index))
            drs_pkg::CSR_START_TRACK: head_in = clip(csr_wdata[TW-1:0]);
            drs_pkg::CSR_START_UP:    dir_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // rotate right on insert, left on removal; untouched positions hold
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ord_slot_in[i]  = ord_slot_ff[i];
         ord_track_in[i] = ord_track_ff[i];
         if (inserting) begin
            if (CW'(i) == lo) begin
               ord_slot_in[i]  = ord_slot_ff[hi[PW-1:0]];
               ord_track_in[i] = cur_track_ff;
            end else if (CW'(i) > lo && CW'(i) <= hi) begin
               ord_slot_in[i]  = ord_slot_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
               ord_track_in[i] = ord_track_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
            end
         end else if (cmd.take) begin
            if (CW'(i) == hi) begin
               ord_slot_in[i]  = ord_slot_ff[pos_idx];
               ord_track_in[i] = take_q;
            end else if (CW'(i) >= lo && CW'(i) < hi) begin
               ord_slot_in[i]  = ord_slot_ff[(i + 1) % QUEUE_DEPTH];
               ord_track_in[i] = ord_track_ff[(i + 1) % QUEUE_DEPTH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= drs_pkg::POL_FCFS;
         circ_ff   <= 1'b0;
         head_ff   <= clip('0);
         dir_ff    <= 1'b1;
         count_ff  <= '0;
         act_ff    <= '0;
         fwd_ff    <= '0;
         ptr_ff    <= '0;
         pos_ff    <= '0;
         mode_ff   <= 1'b0;
         status_ff <= drs_pkg::ST_ACCEPTED;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ord_slot_ff[i] <= PW'(i);
         end
      end else begin
         count_ff  <= count_in;
         act_ff    <= act_in;
         fwd_ff    <= fwd_in;
         ptr_ff    <= ptr_in;
         pos_ff    <= pos_in;
         mode_ff   <= mode_in;
         status_ff <= status_in;
         head_ff   <= head_in;
         dir_ff    <= dir_in;
         ord_slot_ff <= ord_slot_in;
         if (csr_we) begin
            case (drs_pkg::csr_index_type'(csr_index))
               drs_pkg::CSR_POLICY:   policy_ff <= drs_pkg::policy_type'(csr_wdata[1:0]);
               drs_pkg::CSR_CIRCULAR: circ_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      ord_track_ff <= ord_track_in;
      cur_track_ff <= cur_track_in;
      best_ff      <= best_in;
      srv_track_ff <= srv_track_in;
      seek_ff      <= seek_in;
      if (cmd.latch_in) begin
         cur_data_ff <= in_data;
         cur_time_ff <= in_time;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_sub || cmd.ins_wait) begin
         mem_data[ord_slot_ff[count_idx]] <= cur_data_ff;
         mem_time[ord_slot_ff[count_idx]] <= cur_time_ff;
      end
      if (cmd.take) begin
         rd_data_ff <= mem_data[ord_slot_ff[pos_idx]];
         rd_time_ff <= mem_time[ord_slot_ff[pos_idx]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff  <= status_ff;
         rsp_track_ff   <= srv_track_ff;
         rsp_seek_ff    <= seek_ff;
         rsp_data_ff    <= (status_ff == drs_pkg::ST_SERVED) ? rd_data_ff : '0;
         rsp_time_ff    <= (status_ff == drs_pkg::ST_SERVED) ? rd_time_ff : '0;
         rsp_up_ff      <= dir_ff;
         rsp_pending_ff <= drs_pkg::PEND_W'(count_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_track   = rsp_track_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_time    = rsp_time_ff;
   assign rsp_seek    = rsp_seek_ff;
   assign rsp_up      = rsp_up_ff;
   assign rsp_pending = rsp_pending_ff;

endmodule
`default_nettype wire

@@ hdl/disk_request_scheduler.sv @@
// Disk request scheduler: one transaction at a time, one result each; a held result stalls.
// Submit: the sorted insert walks past queued entries; a full or batched submit skips the walk.
// Service: SSTF scans the active entries for the nearest, other policies take the first;
//   a waiting batch merged into the sweep first has each entry placed by its insert walk.
// The sequencer walks the queue one position per cycle; that walk sets the rate.
// Reset (synchronous, active high) empties the queue and loads the default registers.
`default_nettype none
module disk_request_scheduler #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned TRACK_COUNT = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // track_number[11:0], data_amount[27:12],
                                          // request_time[59:28], zero fill
   input  wire logic         req_tuser,   // command: 0 submit, 1 service
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [79:0]       rsp_tdata,   // served_track[11:0], served_data[27:12],
                                          // served_time[59:28], seek_distance[71:60],
                                          // moving_up[72], pending_count[77:73], zero fill
   output logic [1:0]        rsp_tuser,   // status
   // configuration write port
   input  wire logic         csr_we,
   input  wire logic [drs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [drs_pkg::CSR_W-1:0]     csr_wdata
);

   drs_pkg::cmd_type    cmd;
   drs_pkg::stat_type   stat;
   drs_pkg::status_type rsp_status;
   logic [drs_pkg::TRACK_W-1:0] rsp_track;
   logic [drs_pkg::DATA_W-1:0]  rsp_data;
   logic [drs_pkg::TIME_W-1:0]  rsp_time;
   logic [drs_pkg::SEEK_W-1:0]  rsp_seek;
   logic                        rsp_up;
   logic [drs_pkg::PEND_W-1:0]  rsp_pending;

   // Sequencer: decides the walk over the queue and when the result is loaded.
   drs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_service (req_tuser),
      .stat        (stat),
      .req_ready   (req_tready),
      .cmd         (cmd)
   );

   // Datapath: ordered queue of slots, payload memory, head and direction.
   drs_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TRACK_COUNT (TRACK_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_track    (req_tdata[11:0]),
      .in_data     (req_tdata[27:12]),
      .in_time     (req_tdata[59:28]),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_status  (rsp_status),
      .rsp_track   (rsp_track),
      .rsp_data    (rsp_data),
      .rsp_time    (rsp_time),
      .rsp_seek    (rsp_seek),
      .rsp_up      (rsp_up),
      .rsp_pending (rsp_pending)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {2'b00, rsp_pending, rsp_up, rsp_seek, rsp_time, rsp_data, rsp_track};
   assign rsp_tuser = rsp_status;

   localparam logic [drs_pkg::PEND_W-1:0] DEPTH_TRUNC = drs_pkg::PEND_W'(QUEUE_DEPTH);

   // One transaction at a time: an accepted request closes the input next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A rejected submit only happens with the queue full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == drs_pkg::ST_FULL) |-> (rsp_pending == DEPTH_TRUNC))
      else $error("queue-full status with free entries");

   // Nothing served means no head movement and no served track.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != drs_pkg::ST_SERVED) |-> (rsp_seek == '0 && rsp_track == '0))
      else $error("movement reported without a service");

endmodule
`default_nettype wire

@@ tb/sv/tb_disk_request_scheduler.sv @@
// Self-checking testbench for the disk request scheduler: streams submit and
// service transactions under every policy and checks each result against an
// in-bench scheduler model. Depends on drs_pkg and disk_request_scheduler.
module tb_disk_request_scheduler;

   localparam int unsigned DEPTH      = 16;
   localparam int unsigned CYCLE_MAX  = 4000000;

   typedef struct packed {
      logic        cmd;
      logic [11:0] trk;
      logic [15:0] amt;
      logic [31:0] stamp;
   } req_item_type;

   typedef struct packed {
      drs_pkg::status_type status;
      logic [11:0] trk;
      logic [15:0] amt;
      logic [31:0] stamp;
      logic [11:0] seek;
      logic        up;
      logic [4:0]  pending;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we     = 1'b0;
   logic [drs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [drs_pkg::CSR_W-1:0]     csr_wdata = '0;

   disk_request_scheduler dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Scheduler shadow state: slot arrays indexed through the queue-order list.
   drs_pkg::policy_type sch_policy;
   logic        sch_circular;
   logic [11:0] sch_start_track;
   logic        sch_start_up;
   logic [11:0] q_trk   [DEPTH];
   logic [15:0] q_amt   [DEPTH];
   logic [31:0] q_stamp [DEPTH];
   int          q_order [DEPTH];
   logic        q_wait  [DEPTH];
   int          q_count;
   int          fwd_count;
   logic [11:0] head_pos;
   logic        head_up;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          served_total = 0;
   int          full_total = 0;
   int          sent_total = 0;
   bit          hold_off = 1'b0;
   bit          stim_done = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   // True when track a lies strictly ahead of b in the sweep direction.
   function automatic bit ahead(logic [11:0] a, logic [11:0] b);
      return head_up ? (a > b) : (a < b);
   endfunction

   function automatic int active_len();
      int i;
      i = 0;
      while (i < q_count && !q_wait[q_order[i]]) i++;
      return i;
   endfunction

   task automatic slot_insert(int pos, logic [11:0] t, logic [15:0] d, logic [31:0] s,
                              bit w);
      int slot;
      slot = q_order[q_count];
      for (int k = q_count; k > pos; k--) q_order[k] = q_order[k-1];
      q_order[pos] = slot;
      q_trk[slot] = t; q_amt[slot] = d; q_stamp[slot] = s; q_wait[slot] = w;
      q_count++;
   endtask

   task automatic sweep_place(logic [11:0] t, logic [15:0] d, logic [31:0] s);
      int act, p;
      logic [11:0] q;
      act = active_len();
      if (fwd_count > act) fwd_count = act;
      if (sch_policy == drs_pkg::POL_FCFS || sch_policy == drs_pkg::POL_SSTF) begin
         slot_insert(act, t, d, s, 1'b0);
         return;
      end
      if (ahead(t, head_pos)) begin
         p = 0;
         while (p < fwd_count && ahead(t, q_trk[q_order[p]])) p++;
         slot_insert(p, t, d, s, 1'b0);
         fwd_count++;
      end else begin
         p = fwd_count;
         while (p < act) begin
            q = q_trk[q_order[p]];
            if (sch_circular ? !ahead(t, q) : !ahead(q, t)) break;
            p++;
         end
         slot_insert(p, t, d, s, 1'b0);
      end
   endtask

   // Compute the result of one transaction and advance the shadow state.
   task automatic predict_schedule(req_item_type it);
      rsp_item_type r;
      int act, pos, slot, n;
      int unsigned best, dd;
      logic [11:0] tt [DEPTH];
      logic [15:0] td [DEPTH];
      logic [31:0] ts [DEPTH];
      r = '0;
      if (!it.cmd) begin
         if (q_count >= DEPTH) r.status = drs_pkg::ST_FULL;
         else begin
            if (sch_policy == drs_pkg::POL_BATCH)
               slot_insert(q_count, it.trk, it.amt, it.stamp, 1'b1);
            else sweep_place(it.trk, it.amt, it.stamp);
            r.status = drs_pkg::ST_ACCEPTED;
         end
      end else begin
         act = active_len();
         if (fwd_count > act) fwd_count = act;
         // release the frozen batch into the sweep, in arrival order
         if (act == 0 && q_count > 0) begin
            n = q_count;
            for (int i = 0; i < n; i++) begin
               slot = q_order[i];
               tt[i] = q_trk[slot]; td[i] = q_amt[slot]; ts[i] = q_stamp[slot];
               q_wait[slot] = 1'b0;
            end
            q_count = 0; fwd_count = 0;
            for (int i = 0; i < n; i++) sweep_place(tt[i], td[i], ts[i]);
            act = q_count;
         end
         if ((sch_policy == drs_pkg::POL_SWEEP || sch_policy == drs_pkg::POL_BATCH)
             && fwd_count == 0) begin
            if (!sch_circular) head_up = ~head_up;
            fwd_count = act;
         end
         if (act == 0) r.status = drs_pkg::ST_NONE;
         else begin
            pos = 0;
            if (sch_policy == drs_pkg::POL_SSTF) begin
               best = 32'hFFFF_FFFF;
               for (int i = 0; i < act; i++) begin
                  dd = (q_trk[q_order[i]] > head_pos) ? q_trk[q_order[i]] - head_pos
                                                      : head_pos - q_trk[q_order[i]];
                  if (dd < best) begin best = dd; pos = i; end
               end
            end
            slot = q_order[pos];
            for (int k = pos; k < q_count - 1; k++) q_order[k] = q_order[k+1];
            q_order[q_count-1] = slot;
            q_count--;
            if (pos < fwd_count) fwd_count--;
            r.trk = q_trk[slot]; r.amt = q_amt[slot]; r.stamp = q_stamp[slot];
            r.seek = (r.trk > head_pos) ? r.trk - head_pos : head_pos - r.trk;
            head_pos = r.trk;
            r.status = drs_pkg::ST_SERVED;
         end
      end
      r.up = head_up;
      r.pending = q_count[4:0];
      expected_rsps.push_back(r);
   endtask

   task automatic model_reset();
      sch_policy = drs_pkg::POL_FCFS; sch_circular = 1'b0;
      sch_start_track = '0; sch_start_up = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         q_order[i] = i; q_wait[i] = 1'b0;
         q_trk[i] = '0; q_amt[i] = '0; q_stamp[i] = '0;
      end
      q_count = 0; fwd_count = 0;
      head_pos = '0; head_up = 1'b1;
   endtask

   // Write one register on the DUT and in the shadow model; DUT must be idle.
   task automatic csr_write(drs_pkg::csr_index_type idx, logic [drs_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         drs_pkg::CSR_POLICY:      sch_policy = drs_pkg::policy_type'(val[1:0]);
         drs_pkg::CSR_CIRCULAR:    sch_circular = val[0];
         drs_pkg::CSR_START_TRACK: begin sch_start_track = val; head_pos = val; end
         drs_pkg::CSR_START_UP:    begin sch_start_up = val[0]; head_up = val[0]; end
         default: ;
      endcase
   endtask

   function automatic req_item_type make_req(bit c, logic [11:0] t, logic [15:0] d,
                                             logic [31:0] s);
      req_item_type it;
      it.cmd = c; it.trk = t; it.amt = d; it.stamp = s;
      return it;
   endfunction

   function automatic req_item_type rand_req(int submit_pct);
      return make_req($urandom_range(99) >= submit_pct, 12'($urandom_range(4095)),
                      16'($urandom_range(65535)), $urandom());
   endfunction

   // Wait until the DUT has drained all queued work, then let it settle.
   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   // Driver: hold each transaction until accepted, then idle a random gap.
   int drv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_schedule(pending_reqs.pop_front());
            sent_total++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (drv_gap > 0) begin
            drv_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].cmd;
            req_tdata  <= {4'b0, pending_reqs[0].stamp, pending_reqs[0].amt,
                           pending_reqs[0].trk};
            drv_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: accept results with random stalls and compare against the model.
   int mon_gap = 0;
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status  = drs_pkg::status_type'(rsp_tuser);
            got.trk     = rsp_tdata[11:0];
            got.amt     = rsp_tdata[27:12];
            got.stamp   = rsp_tdata[59:28];
            got.seek    = rsp_tdata[71:60];
            got.up      = rsp_tdata[72];
            got.pending = rsp_tdata[77:73];
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status == drs_pkg::ST_SERVED) served_total++;
               if (got.status == drs_pkg::ST_FULL) full_total++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at cycle %0d: expected %p, got %p",
                              cycle_count, want, got);
               end
            end
            mon_gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(7);
         end
         if (hold_off) rsp_tready <= 1'b0;
         else if (mon_gap > 0) begin
            mon_gap--;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   // Long receiver hold-off so the DUT backs up onto the request channel.
   task automatic long_hold();
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   endtask

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      drs_pkg::policy_type pol;
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty service, extremes, fill to full and overflow, FCFS.
      pending_reqs.push_back(make_req(1'b1, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(1'b0, 12'h000, 16'h0000, 32'h0000_0000));
      pending_reqs.push_back(make_req(1'b0, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF));
      for (int i = 0; i < 15; i++)
         pending_reqs.push_back(make_req(1'b0, 12'(i * 250), 16'(i), 32'(i)));
      for (int i = 0; i < 4; i++)
         pending_reqs.push_back(make_req(1'b1, 12'd0, 16'd0, 32'd0));
      drain();

      // SSTF with equal-distance ties.
      csr_write(drs_pkg::CSR_POLICY, drs_pkg::CSR_W'(drs_pkg::POL_SSTF));
      csr_write(drs_pkg::CSR_START_TRACK, 12'd100);
      pending_reqs.push_back(make_req(1'b0, 12'd110, 16'd1, 32'd1));
      pending_reqs.push_back(make_req(1'b0, 12'd90, 16'd2, 32'd2));
      pending_reqs.push_back(make_req(1'b0, 12'd110, 16'd3, 32'd3));
      for (int i = 0; i < 4; i++)
         pending_reqs.push_back(make_req(1'b1, 12'd0, 16'd0, 32'd0));
      drain();

      // Random phases across policies, circular mode, start track and direction.
      for (int ph = 0; ph < 16; ph++) begin
         pol = drs_pkg::policy_type'(ph % 4);
         csr_write(drs_pkg::CSR_POLICY, drs_pkg::CSR_W'(pol));
         csr_write(drs_pkg::CSR_CIRCULAR, drs_pkg::CSR_W'((ph / 4) % 2));
         csr_write(drs_pkg::CSR_START_TRACK, (ph % 3 == 0) ? 12'd0 :
                   (ph % 3 == 1) ? 12'hFFF : 12'($urandom_range(4095)));
         csr_write(drs_pkg::CSR_START_UP, drs_pkg::CSR_W'((ph / 2) % 2));
         if (ph % 4 == 2) begin
            // sweep: track exactly at the head
            pending_reqs.push_back(make_req(1'b0, sch_start_track, 16'h55, 32'h55));
         end
         for (int i = 0; i < 100; i++)
            pending_reqs.push_back(rand_req((i % 40 < 25) ? 70 : 35));
         if (ph == 5) begin
            for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req(100));
            long_hold();
         end
         drain();
      end
      // Return to a policy change with a frozen batch still waiting.
      csr_write(drs_pkg::CSR_POLICY, drs_pkg::CSR_W'(drs_pkg::POL_BATCH));
      for (int i = 0; i < 6; i++) pending_reqs.push_back(rand_req(100));
      drain();
      csr_write(drs_pkg::CSR_POLICY, drs_pkg::CSR_W'(drs_pkg::POL_FCFS));
      for (int i = 0; i < 10; i++) pending_reqs.push_back(rand_req(30));
      drain();
      stim_done = 1'b1;

      $display("Sent %0d transactions over all four policies and both sweep modes;",
               sent_total);
      $display("%0d requests served, %0d submits rejected as full.",
               served_total, full_total);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/drs_pkg.sv
hdl/drs_ctrl.sv
hdl/drs_datapath.sv
hdl/disk_request_scheduler.sv
tb/sv/tb_disk_request_scheduler.sv
